[hw/rtl/kwsc_pkg.sv]
`default_nettype none

package kwsc_pkg;

    localparam int LETTERS = 26;
    localparam int IDX_W   = 5;
    localparam int CHAR_W  = 8;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LETTERS - 1);

    typedef enum logic [1:0] {
        KIND_KEY  = 2'd0,
        KIND_SEAL = 2'd1,
        KIND_ENC  = 2'd2,
        KIND_DEC  = 2'd3
    } t_kind;

    // Classification of one byte.
    typedef struct packed {
        logic             is_letter;
        logic             lower;
        logic [IDX_W-1:0] idx;
    } t_letter;

    // Request to the table unit: optional restart, then optional placement.
    typedef struct packed {
        logic             clr;
        logic             vld;
        logic [IDX_W-1:0] idx;
    } t_place_req;

endpackage

`default_nettype wire

[hw/rtl/kwsc_letter.sv]
`default_nettype none

module kwsc_letter
    import kwsc_pkg::*;
(
    input  wire logic [CHAR_W-1:0] i_char,
    output t_letter                o_letter
);

    logic             upper_hit;
    logic             lower_hit;
    logic [CHAR_W-1:0] upper_off;
    logic [CHAR_W-1:0] lower_off;

    assign upper_hit = (i_char >= CHAR_UPPER_A) && (i_char <= CHAR_UPPER_Z);
    assign lower_hit = (i_char >= CHAR_LOWER_A) && (i_char <= CHAR_LOWER_Z);
    assign upper_off = i_char - CHAR_UPPER_A;
    assign lower_off = i_char - CHAR_LOWER_A;

    always_comb begin
        o_letter.is_letter = upper_hit || lower_hit;
        o_letter.lower     = lower_hit;
        if (lower_hit) begin
            o_letter.idx = lower_off[IDX_W-1:0];
        end else if (upper_hit) begin
            o_letter.idx = upper_off[IDX_W-1:0];
        end else begin
            o_letter.idx = '0;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/kwsc_tables.sv]
`default_nettype none

module kwsc_tables
    import kwsc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_place_req       i_req,
    input  wire logic [IDX_W-1:0] i_lookup_idx,
    output logic [IDX_W-1:0]      o_fwd,
    output logic [IDX_W-1:0]      o_inv
);

    logic [IDX_W-1:0]   r_fwd [LETTERS];
    logic [IDX_W-1:0]   r_inv [LETTERS];
    logic [LETTERS-1:0] r_used;
    logic [IDX_W-1:0]   r_fill;

    logic [LETTERS-1:0] used_now;
    logic [IDX_W-1:0]   fill_now;
    logic               do_place;
    logic [LETTERS-1:0] n_used;
    logic [IDX_W-1:0]   n_fill;

    // A restart and a placement may arrive together; the placement then
    // sees an empty map.
    assign used_now = i_req.clr ? '0 : r_used;
    assign fill_now = i_req.clr ? '0 : r_fill;
    assign do_place = i_req.vld && (i_req.idx < IDX_W'(LETTERS))
                      && (fill_now < IDX_W'(LETTERS)) && !used_now[i_req.idx];

    always_comb begin
        n_used = used_now;
        n_fill = fill_now;
        if (do_place) begin
            n_used[i_req.idx] = 1'b1;
            n_fill            = fill_now + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LETTERS; i++) begin
                r_fwd[i] <= IDX_W'(i);
                r_inv[i] <= IDX_W'(i);
            end
            r_used <= '0;
            r_fill <= '0;
        end else begin
            r_used <= n_used;
            r_fill <= n_fill;
            if (do_place) begin
                r_fwd[fill_now]  <= i_req.idx;
                r_inv[i_req.idx] <= fill_now;
            end
        end
    end

    always_comb begin
        if (i_lookup_idx < IDX_W'(LETTERS)) begin
            o_fwd = r_fwd[i_lookup_idx];
            o_inv = r_inv[i_lookup_idx];
        end else begin
            o_fwd = '0;
            o_inv = '0;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/keyword_substitution_cipher.sv]
// Keyword substitution cipher. A command is taken when start is high and busy is low.
// Keyword letters and encrypt or decrypt commands occupy the block for the accept
// cycle and the execute state through the single table-placement unit, and busy is
// high in that state, so a new command cannot be taken before it ends. Encrypt and
// decrypt give their result on o_char_out with o_valid high for exactly one cycle, the
// cycle after the execute state; the receiver cannot stall, so it must take the byte
// then. A seal command on an unsealed alphabet walks the placement unit over the
// letters A to Z one per cycle and keeps busy high until the walk reaches Z; other
// commands give no result. After reset the alphabet is the identity and sealed.
`default_nettype none

module keyword_substitution_cipher
    import kwsc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        i_kind,
    input  wire logic [CHAR_W-1:0] i_char_in,
    output logic                   o_valid,
    output logic [CHAR_W-1:0]      o_char_out
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEAL
    } t_state;

    t_state            r_state;
    t_kind             r_kind;
    logic [CHAR_W-1:0] r_char;
    logic [IDX_W-1:0]  r_cnt;
    logic              r_sealed;
    logic              r_valid;
    logic [CHAR_W-1:0] r_char_out;

    t_letter           letter;
    t_place_req        req;
    logic [IDX_W-1:0]  fwd;
    logic [IDX_W-1:0]  inv;
    logic [IDX_W-1:0]  mapped;
    logic [CHAR_W-1:0] n_char_out;

    kwsc_letter u_letter (
        .i_char   (r_char),
        .o_letter (letter)
    );

    kwsc_tables u_tables (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .i_lookup_idx (letter.idx),
        .o_fwd        (fwd),
        .o_inv        (inv)
    );

    always_comb begin
        req = '0;
        if (r_state == ST_EXEC && r_kind == KIND_KEY && letter.is_letter) begin
            req.clr = r_sealed;
            req.vld = 1'b1;
            req.idx = letter.idx;
        end else if (r_state == ST_SEAL) begin
            req.vld = 1'b1;
            req.idx = r_cnt;
        end
    end

    assign mapped = (r_kind == KIND_ENC) ? fwd : inv;

    always_comb begin
        if (letter.is_letter) begin
            n_char_out = (letter.lower ? CHAR_LOWER_A : CHAR_UPPER_A)
                         + CHAR_W'(mapped);
        end else begin
            n_char_out = r_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_sealed <= 1'b1;
            r_valid  <= 1'b0;
            r_cnt    <= '0;
            r_kind   <= KIND_KEY;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_kind  <= t_kind'(i_kind);
                        r_char  <= i_char_in;
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_state <= ST_IDLE;
                    case (r_kind)
                        KIND_KEY: begin
                            if (letter.is_letter) begin
                                r_sealed <= 1'b0;
                            end
                        end
                        KIND_SEAL: begin
                            if (!r_sealed) begin
                                r_cnt   <= '0;
                                r_state <= ST_SEAL;
                            end
                        end
                        KIND_ENC, KIND_DEC: begin
                            r_valid    <= 1'b1;
                            r_char_out <= n_char_out;
                        end
                        default: begin
                            r_state <= ST_IDLE;
                        end
                    endcase
                end
                ST_SEAL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_IDX) begin
                        r_sealed <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy       = (r_state != ST_IDLE);
    assign o_valid    = r_valid;
    assign o_char_out = r_char_out;

endmodule

`default_nettype wire

[hw/rtl/kwsc_checker.sv]
`default_nettype none

module kwsc_protocol_checker
    import kwsc_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic [1:0]        i_kind,
    input wire logic              o_valid
);

    // An accepted command always occupies the block for its execute cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    // A result strobe follows an execute cycle and never repeats.
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a preceding execute cycle");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // A result only comes from an encrypt or decrypt command.
    a_valid_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_kind == KIND_KEY || i_kind == KIND_SEAL) |=> ##1 !o_valid)
        else $error("result transfer from a keyword or seal command");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_valid)
        else $error("block not quiet after reset");

endmodule

bind keyword_substitution_cipher kwsc_protocol_checker u_kwsc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_kind     (i_kind),
    .o_valid    (o_valid)
);

`default_nettype wire

[bench/kwsc_checker.sv]
`timescale 1ns / 1ps

// Watches the command and result channels, keeps its own copy of the cipher
// tables and compares every result byte with the predicted one.
module kwsc_checker
    import kwsc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_busy,
    input  wire logic [1:0]        i_kind,
    input  wire logic [CHAR_W-1:0] i_char_in,
    input  wire logic              i_valid,
    input  wire logic [CHAR_W-1:0] i_char_out,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked
);

    typedef struct {
        t_kind             cmd_kind;
        logic [CHAR_W-1:0] cmd_char;
        logic [CHAR_W-1:0] out_char;
    } t_text_result;

    logic [IDX_W-1:0]   enc_map [LETTERS];
    logic [IDX_W-1:0]   dec_map [LETTERS];
    logic [LETTERS-1:0] placed;
    int                 fill;
    bit                 alphabet_sealed;
    t_text_result       expected_bytes[$];
    t_text_result       oldest;

    function automatic bit classify(input logic [CHAR_W-1:0] c,
                                    output logic [IDX_W-1:0] idx,
                                    output logic lower);
        idx   = '0;
        lower = 1'b0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            idx = IDX_W'(c - CHAR_UPPER_A);
            return 1'b1;
        end
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            idx   = IDX_W'(c - CHAR_LOWER_A);
            lower = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic append_letter(input logic [IDX_W-1:0] idx);
        if (fill >= LETTERS || placed[idx])
            return;
        enc_map[fill] = idx;
        dec_map[idx]  = IDX_W'(fill);
        placed[idx]   = 1'b1;
        fill++;
    endtask

    task automatic apply_command(input t_kind k, input logic [CHAR_W-1:0] c);
        logic [IDX_W-1:0] idx;
        logic             lower;
        logic [IDX_W-1:0] mapped;
        bit               is_letter;
        t_text_result     res;
        is_letter = classify(c, idx, lower);
        case (k)
            KIND_KEY: begin
                // Non-letters are dropped without touching the keyword state.
                if (is_letter) begin
                    if (alphabet_sealed) begin
                        placed          = '0;
                        fill            = 0;
                        alphabet_sealed = 1'b0;
                    end
                    append_letter(idx);
                end
            end
            KIND_SEAL: begin
                if (!alphabet_sealed) begin
                    for (int i = 0; i < LETTERS; i++)
                        append_letter(IDX_W'(i));
                    alphabet_sealed = 1'b1;
                end
            end
            default: begin
                res.cmd_kind = k;
                res.cmd_char = c;
                if (!is_letter) begin
                    res.out_char = c;
                end else begin
                    mapped = (k == KIND_ENC) ? enc_map[idx] : dec_map[idx];
                    if (mapped >= LETTERS)
                        mapped = '0;
                    res.out_char = (lower ? CHAR_LOWER_A : CHAR_UPPER_A) + CHAR_W'(mapped);
                end
                expected_bytes.push_back(res);
            end
        endcase
    endtask

    task automatic note_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%t ERROR: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LETTERS; i++) begin
                enc_map[i] = IDX_W'(i);
                dec_map[i] = IDX_W'(i);
            end
            placed          = '0;
            fill            = 0;
            alphabet_sealed = 1'b1;
            o_fail_count    = 0;
            o_checked       = 0;
            expected_bytes.delete();
        end else begin
            // A result always belongs to an earlier transfer, so check it first.
            if (i_valid) begin
                if (expected_bytes.size() == 0) begin
                    note_failure($sformatf("result 0x%02h with no command waiting",
                                           i_char_out));
                end else begin
                    oldest = expected_bytes.pop_front();
                    o_checked++;
                    if (i_char_out !== oldest.out_char)
                        note_failure($sformatf("%s 0x%02h: char_out expected 0x%02h, got 0x%02h",
                                               oldest.cmd_kind.name(), oldest.cmd_char,
                                               oldest.out_char, i_char_out));
                end
            end
            if (i_start && !i_busy)
                apply_command(t_kind'(i_kind), i_char_in);
        end
        o_pending = expected_bytes.size();
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import kwsc_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int CALM_TAIL    = 200;
    localparam int QUIET_LIMIT  = 5000;

    typedef struct packed {
        t_kind             k;
        logic [CHAR_W-1:0] c;
    } t_cmd;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_kind;
    logic [CHAR_W-1:0] i_char_in;
    logic              o_valid;
    logic [CHAR_W-1:0] o_char_out;

    int fail_count;
    int pending;
    int checked;
    int quiet_cycles;
    int n_sent;
    int n_key;
    int n_seal;
    int n_text;
    bit sender_idles;

    // Reset alphabet, boundary bytes, the ignored cases and text while unsealed.
    t_cmd directed[24] = '{
        '{KIND_ENC, 8'h41}, '{KIND_DEC, 8'h7A}, '{KIND_ENC, 8'h00}, '{KIND_DEC, 8'hFF},
        '{KIND_ENC, 8'h40}, '{KIND_ENC, 8'h5B}, '{KIND_DEC, 8'h60}, '{KIND_ENC, 8'h7B},
        '{KIND_SEAL, 8'h00}, '{KIND_KEY, 8'h5A}, '{KIND_KEY, 8'h65}, '{KIND_KEY, 8'h7A},
        '{KIND_KEY, 8'h80}, '{KIND_KEY, 8'h31}, '{KIND_ENC, 8'h61}, '{KIND_DEC, 8'h45},
        '{KIND_SEAL, 8'hFF}, '{KIND_ENC, 8'h4D}, '{KIND_DEC, 8'h71}, '{KIND_KEY, 8'h62},
        '{KIND_ENC, 8'h62}, '{KIND_SEAL, 8'h41}, '{KIND_DEC, 8'h42}, '{KIND_ENC, 8'h59}
    };

    keyword_substitution_cipher u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_kind     (i_kind),
        .i_char_in  (i_char_in),
        .o_valid    (o_valid),
        .o_char_out (o_char_out)
    );

    kwsc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_kind       (i_kind),
        .i_char_in    (i_char_in),
        .i_valid      (o_valid),
        .i_char_out   (o_char_out),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [CHAR_W-1:0] rand_letter();
        logic [CHAR_W-1:0] base;
        base = $urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A;
        return base + CHAR_W'($urandom_range(0, LETTERS - 1));
    endfunction

    function automatic logic [CHAR_W-1:0] rand_non_letter();
        logic [CHAR_W-1:0] c;
        do begin
            c = CHAR_W'($urandom_range(0, 255));
        end while ((c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
                   (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z));
        return c;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_cmd(input t_kind k, input logic [CHAR_W-1:0] c);
        int gap;
        if (sender_idles && n_sent < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 4) == 0) begin
            gap   = $urandom_range(1, 17);
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start     <= 1'b1;
        i_kind    <= k;
        i_char_in <= c;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        n_sent++;
        case (k)
            KIND_KEY:  n_key++;
            KIND_SEAL: n_seal++;
            default:   n_text++;
        endcase
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic send_text_run(input int len);
        t_kind k;
        for (int n = 0; n < len; n++) begin
            k = $urandom_range(0, 1) ? KIND_ENC : KIND_DEC;
            send_cmd(k, ($urandom_range(0, 3) != 0) ? rand_letter()
                                                    : CHAR_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int perm[LETTERS];
        int pick;
        int tmp;
        int len;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_kind       = KIND_KEY;
        i_char_in    = '0;
        n_sent       = 0;
        n_key        = 0;
        n_seal       = 0;
        n_text       = 0;
        sender_idles = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[n])
            send_cmd(directed[n].k, directed[n].c);
        wait_drained();

        n_sent = 0;
        while (n_sent < RANDOM_ITEMS) begin
            sender_idles = ($urandom_range(0, 3) != 0);
            if (n_sent < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 14) == 0)
                wait_drained();
            if ($urandom_range(0, 9) < 7) begin
                // Session: keyword (a text byte may fall among its bytes), seal, then a run of text.
                if ($urandom_range(0, 9) == 0) begin
                    for (int i = 0; i < LETTERS; i++)
                        perm[i] = i;
                    for (int i = LETTERS - 1; i > 0; i--) begin
                        pick       = $urandom_range(0, i);
                        tmp        = perm[i];
                        perm[i]    = perm[pick];
                        perm[pick] = tmp;
                    end
                    for (int i = 0; i < LETTERS; i++)
                        send_cmd(KIND_KEY, ($urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A)
                                           + CHAR_W'(perm[i]));
                end else begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
                    for (int i = 0; i < len; i++) begin
                        if ($urandom_range(0, 11) == 0)
                            send_cmd(KIND_KEY, rand_non_letter());
                        else
                            send_cmd(KIND_KEY, rand_letter());
                        if ($urandom_range(0, 15) == 0)
                            send_text_run(1);
                    end
                end
                send_cmd(KIND_SEAL, CHAR_W'($urandom_range(0, 255)));
                if ($urandom_range(0, 7) == 0)
                    send_cmd(KIND_SEAL, CHAR_W'($urandom_range(0, 255)));
                send_text_run($urandom_range(1, 12));
            end else begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    send_cmd(t_kind'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)));
            end
        end

        wait_drained();
        repeat (40) @(negedge i_clk);

        $display("Covered %0d keyword bytes, %0d seal commands and %0d text bytes,",
                 n_key, n_seal, n_text);
        $display("with %0d cipher results compared against the predicted bytes.", checked);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/kwsc_pkg.sv
hw/rtl/kwsc_letter.sv
hw/rtl/kwsc_tables.sv
hw/rtl/keyword_substitution_cipher.sv
hw/rtl/kwsc_checker.sv
bench/kwsc_checker.sv
bench/tb_top.sv
